@@ rtl/ssl_pkg.sv @@
// ssl_pkg: shared types, constants and the CORDIC angle table for the
// steering law block. No dependencies.
`timescale 1ns / 1ps
package ssl_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int DATA_WIDTH_DEF   = 16;
  localparam int TABLE_LEN        = 24;
  localparam int ANGLE_90_Q7      = 11520;

  // register indexes
  localparam logic REG_GAIN_K      = 1'b0;
  localparam logic REG_STEER_LIMIT = 1'b1;

  typedef struct packed {
    logic signed [15:0] cross_track_error;
    logic signed [15:0] heading_error;
    logic        [15:0] speed;
  } in_beat_t;

  typedef struct packed {
    logic signed [14:0] steer_angle;
    logic               clamped;
  } out_beat_t;

  // atan(2^-i) in degrees, 16 fractional bits
  function automatic logic [21:0] atan_entry(input int i);
    logic [21:0] r;
    case (i)
      0: r = 22'd2949120;   1: r = 22'd1740967;  2: r = 22'd919879;
      3: r = 22'd466945;    4: r = 22'd234379;   5: r = 22'd117304;
      6: r = 22'd58666;     7: r = 22'd29335;    8: r = 22'd14668;
      9: r = 22'd7334;     10: r = 22'd3667;    11: r = 22'd1833;
      12: r = 22'd917;     13: r = 22'd458;     14: r = 22'd229;
      15: r = 22'd115;     16: r = 22'd57;      17: r = 22'd29;
      18: r = 22'd14;      19: r = 22'd7;       20: r = 22'd4;
      21: r = 22'd2;       22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/stanley_steering_law.sv @@
// stanley_steering_law: pipelined Stanley lateral steering law.
// Depends on ssl_pkg.
`timescale 1ns / 1ps
// Usage:
//   in_valid/in_ready carry one beat {cross_track_error, heading_error, speed}.
//   out_valid/out_ready carry one beat {steer_angle, clamped}.
//   cfg_we/cfg_index/cfg_data write gain_k (index 0) and steer_limit (index 1);
//   write only while the pipe is empty.
// Pipeline: stage 0 forms k*e and 64*v (one 17x16 multiply), then one
//   register stage per CORDIC iteration (CORDIC_STEPS stages), then a
//   rounding stage and a clamp stage. Throughput is one beat per cycle
//   while the output register is not stalled.
// Stalls: the whole pipe advances only when the output register is free or
//   being taken, so in_ready = !out_valid || out_ready; nothing is lost.
// Reset (rst, synchronous): clears all valid bits and loads gain_k = 1.0,
//   steer_limit = 28 degrees.
module stanley_steering_law #(
  parameter int CORDIC_STEPS = ssl_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ssl_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ssl_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int NS = CORDIC_STEPS;
  // k*e up to 2^31, x up to 2^22; CORDIC growth ~1.65, keep headroom
  localparam int XW = 35;
  localparam int ZW = 26;

  logic [15:0] gain_k;
  logic [13:0] steer_limit;
  logic        adv;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_k      <= 16'd256;
      steer_limit <= 14'd3584;
    end else if (cfg_we) begin
      if (cfg_index == ssl_pkg::REG_GAIN_K) gain_k <= cfg_data;
      else steer_limit <= cfg_data[13:0];
    end
  end

  // stage 0: products
  logic                 s0_v;
  logic signed [XW-1:0] s0_x, s0_y;
  logic signed [15:0]   s0_psi;
  logic signed [32:0]   ke;
  assign ke = $signed({1'b0, gain_k}) * in_data.cross_track_error;
  always_ff @(posedge clk) begin
    if (rst) s0_v <= 1'b0;
    else if (adv) s0_v <= in_valid;
    if (adv) begin
      s0_y   <= XW'(ke);
      s0_x   <= XW'({in_data.speed, 6'd0});
      s0_psi <= in_data.heading_error;
    end
  end

  // CORDIC stages, one iteration each
  logic                 cv [NS+1];
  logic signed [XW-1:0] cx [NS+1];
  logic signed [XW-1:0] cy [NS+1];
  logic signed [ZW-1:0] cz [NS+1];
  logic signed [15:0]   cp [NS+1];
  logic                 cz0 [NS+1];
  logic signed [1:0]    csg [NS+1];

  assign cv[0]  = s0_v;
  assign cx[0]  = s0_x;
  assign cy[0]  = s0_y;
  assign cz[0]  = '0;
  assign cp[0]  = s0_psi;
  assign cz0[0] = (s0_x == '0);
  assign csg[0] = (s0_y > 0) ? 2'sd1 : ((s0_y < 0) ? -2'sd1 : 2'sd0);

  for (genvar i = 0; i < NS; i++) begin : g_step
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] a;
    assign xs = cx[i] >>> i;
    assign ys = cy[i] >>> i;
    assign a  = ZW'($signed({1'b0, ssl_pkg::atan_entry(i)}));
    always_ff @(posedge clk) begin
      if (rst) cv[i+1] <= 1'b0;
      else if (adv) cv[i+1] <= cv[i];
      if (adv) begin
        if (!cy[i][XW-1]) begin
          cx[i+1] <= cx[i] + ys;
          cy[i+1] <= cy[i] - xs;
          cz[i+1] <= cz[i] + a;
        end else begin
          cx[i+1] <= cx[i] - ys;
          cy[i+1] <= cy[i] + xs;
          cz[i+1] <= cz[i] - a;
        end
        cp[i+1]  <= cp[i];
        cz0[i+1] <= cz0[i];
        csg[i+1] <= csg[i];
      end
    end
  end

  // round stage: Q16 -> Q7, saturate to 90, zero-speed rule
  logic                 r_v;
  logic signed [16:0]   r_sum;
  logic signed [ZW-1:0] zr;
  logic signed [16:0]   at;
  assign zr = (cz[NS] + ZW'(256)) >>> 9;
  always_comb begin
    if (cz0[NS]) at = 17'(csg[NS]) * 17'sd11520;
    else if (zr > ZW'(ssl_pkg::ANGLE_90_Q7)) at = 17'sd11520;
    else if (zr < -ZW'(ssl_pkg::ANGLE_90_Q7)) at = -17'sd11520;
    else at = zr[16:0];
  end
  always_ff @(posedge clk) begin
    if (rst) r_v <= 1'b0;
    else if (adv) r_v <= cv[NS];
    if (adv) r_sum <= at + 17'(cp[NS]);
  end

  // clamp stage / output register
  logic signed [16:0] lim;
  assign lim = (steer_limit > 14'd11520) ? 17'sd11520 : 17'($signed({1'b0, steer_limit}));
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= r_v;
    if (adv) begin
      if (r_sum > lim) begin
        out_data.steer_angle <= lim[14:0];
        out_data.clamped     <= 1'b1;
      end else if (r_sum < -lim) begin
        out_data.steer_angle <= 15'(-lim);
        out_data.clamped     <= 1'b1;
      end else begin
        out_data.steer_angle <= r_sum[14:0];
        out_data.clamped     <= 1'b0;
      end
    end
  end

  // output magnitude never exceeds ninety degrees
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.steer_angle <= 15'sd11520 &&
                   out_data.steer_angle >= -15'sd11520))
    else $error("steer_angle out of range");
  // stalled result is held
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  // ready follows the output register
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule
